/* rtl/i2cram_pkg.sv */
package i2cram_pkg;

    localparam int MAX_BYTES  = 4;
    // data fields hold four bytes, so the count never goes above that
    localparam int BYTE_LIMIT = (MAX_BYTES < 4) ? MAX_BYTES : 4;

    localparam int PHASE_W    = 16;
    localparam int ACK_W      = 12;
    localparam int CFG_W      = 16;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 40;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd10;
    localparam logic [ACK_W-1:0]   ACK_TIMEOUT_RST = 12'd2500;

    typedef enum logic [0:0] {
        t_cfg_phase_ticks = 1'b0,
        t_cfg_ack_timeout = 1'b1
    } t_cfg_reg;

    typedef enum logic [0:0] {
        MODE_CMD  = 1'b0,
        MODE_TICK = 1'b1
    } t_mode;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_ST_A  = 4'd1,
        PH_ST_B  = 4'd2,
        PH_ST_C  = 4'd3,
        PH_TX_LO = 4'd4,
        PH_TX_HI = 4'd5,
        PH_AK_LO = 4'd6,
        PH_AK_HI = 4'd7,
        PH_RX_LO = 4'd8,
        PH_RX_HI = 4'd9,
        PH_MA_LO = 4'd10,
        PH_MA_HI = 4'd11,
        PH_SP_A  = 4'd12,
        PH_SP_B  = 4'd13,
        PH_SP_C  = 4'd14,
        PH_RS_A  = 4'd15
    } t_phase;

    typedef enum logic [1:0] {
        SG_ADDR_W = 2'd0,
        SG_INDEX  = 2'd1,
        SG_WDATA  = 2'd2,
        SG_ADDR_R = 2'd3
    } t_stage;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  dev_addr;
        logic [7:0]  reg_index;
        logic        is_read;
        logic [2:0]  byte_count;
        logic [31:0] write_data;
        logic        sda_in;
    } t_item;

    typedef struct packed {
        logic        scl_out;
        logic        sda_out;
        logic        sda_drive;
        logic        busy_res;
        logic        done_res;
        logic        nack_error;
        logic [31:0] read_data;
    } t_res;

endpackage

/* rtl/i2c_register_access_master.sv */
// Bit-level I2C master for register reads and writes, driven by a stream of items.
// Slave side: tuser = mode (0 command, 1 bus tick). A command latches address,
// register index, direction, byte count and write data only when the bus is idle;
// each tick item advances the bus timing by one step and carries the sampled SDA.
// Master side: one result item per input item with SCL/SDA levels, SDA drive enable,
// busy, a done pulse, the acknowledge-timeout error flag and the big-endian read data.
// The result is registered, valid in the cycle after input acceptance; throughput
// is one item per cycle while the receiver takes results.
// Bus pacing is set by the tick rate, phase_ticks and the slave's acknowledge.
// When the receiver stalls, the finished result waits in the output register and
// o_s_tready drops, so no item is lost; it rises again as soon as the result is taken.
// Reset (synchronous, active low) idles the bus, clears the state, drops the output
// valid and restores phase_ticks to 10 and ack_timeout to 2500.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 phase_ticks,
// 1 ack_timeout) at the clock edge; write only while no transaction is running.
module i2c_register_access_master (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // dev_addr[7:0], reg_index[15:8], is_read[16], byte_count[19:17],
    // write_data[51:20], sda_in[52], zero fill
    input  logic [i2cram_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // mode[0]
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // scl_out[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
    // nack_error[5], read_data[37:6], zero fill
    output logic [i2cram_pkg::M_TDATA_W-1:0]     o_m_tdata,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [i2cram_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [i2cram_pkg::PHASE_W-1:0] r_phase_ticks;
    logic [i2cram_pkg::ACK_W-1:0]   r_ack_timeout;
    i2cram_pkg::t_item              w_item;
    i2cram_pkg::t_res               w_res;
    i2cram_pkg::t_res               w_out;
    logic                           w_accept;

    assign w_accept = i_s_tvalid && o_s_tready;

    assign w_item.mode       = i2cram_pkg::t_mode'(i_s_tuser);
    assign w_item.dev_addr   = i_s_tdata[7:0];
    assign w_item.reg_index  = i_s_tdata[15:8];
    assign w_item.is_read    = i_s_tdata[16];
    assign w_item.byte_count = i_s_tdata[19:17];
    assign w_item.write_data = i_s_tdata[51:20];
    assign w_item.sda_in     = i_s_tdata[52];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cram_pkg::PHASE_TICKS_RST;
            r_ack_timeout <= i2cram_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i2cram_pkg::t_cfg_reg'(i_cfg_index))
                i2cram_pkg::t_cfg_phase_ticks: r_phase_ticks <= i_cfg_data;
                i2cram_pkg::t_cfg_ack_timeout:
                    r_ack_timeout <= i_cfg_data[i2cram_pkg::ACK_W-1:0];
                default: ;
            endcase
        end
    end

    i2cram_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_item        (w_item),
        .i_phase_ticks (r_phase_ticks),
        .i_ack_timeout (r_ack_timeout),
        .o_res         (w_res)
    );

    i2cram_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_res      (w_res),
        .i_m_tready (i_m_tready),
        .o_s_ready  (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_res      (w_out)
    );

    assign o_m_tdata = {2'b00, w_out.read_data, w_out.nack_error, w_out.done_res,
                        w_out.busy_res, w_out.sda_drive, w_out.sda_out, w_out.scl_out};

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_res.done_res |-> !w_res.busy_res)
        else $error("done reported while still busy");

    a_nack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_res.nack_error |-> w_res.done_res && (w_res.read_data == 32'd0))
        else $error("nack error without done or with read data");

    a_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_res.sda_drive |-> w_res.sda_out)
        else $error("released sda reported low");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_m_tvalid && (w_out == $past(w_res)))
        else $error("accepted item did not reach the result register");
`endif

endmodule

/* rtl/i2cram_core.sv */
module i2cram_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  i2cram_pkg::t_item                    i_item,
    input  logic [i2cram_pkg::PHASE_W-1:0]       i_phase_ticks,
    input  logic [i2cram_pkg::ACK_W-1:0]         i_ack_timeout,
    output i2cram_pkg::t_res                     o_res
);

    i2cram_pkg::t_phase              r_phase, n_phase;
    i2cram_pkg::t_stage              r_stage, n_stage;
    logic [i2cram_pkg::PHASE_W-1:0]  r_timer, n_timer;
    logic [2:0]                      r_bit, n_bit;
    logic [2:0]                      r_left, n_left;
    logic [7:0]                      r_shift, n_shift;
    logic [i2cram_pkg::ACK_W-1:0]    r_ack, n_ack;
    logic [31:0]                     r_accum, n_accum;
    logic [7:0]                      r_addr, n_addr;
    logic [7:0]                      r_index, n_index;
    logic [31:0]                     r_wdata, n_wdata;
    logic                            r_is_read, n_is_read;
    logic                            r_abort, n_abort;
    logic                            n_done;

    logic [i2cram_pkg::PHASE_W-1:0]  w_len;
    logic [i2cram_pkg::PHASE_W-1:0]  w_tick_cnt;
    logic [2:0]                      w_count;
    logic [2:0]                      w_left_dec;
    logic [4:0]                      w_wshift;
    logic                            w_tx_bit;
    logic                            w_ma_bit;

    assign w_len      = (i_phase_ticks == '0) ? i2cram_pkg::PHASE_W'(1) : i_phase_ticks;
    assign w_tick_cnt = r_timer + 1'b1;
    assign w_left_dec = (r_left != 3'd0) ? (r_left - 3'd1) : 3'd0;

    always_comb begin
        w_count = i_item.byte_count;
        if (w_count == 3'd0) begin
            w_count = 3'd1;
        end
        if (w_count > 3'(i2cram_pkg::BYTE_LIMIT)) begin
            w_count = 3'(i2cram_pkg::BYTE_LIMIT);
        end
        w_wshift = {2'(3'd4 - w_count), 3'b000};
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_stage   = r_stage;
        n_timer   = r_timer;
        n_bit     = r_bit;
        n_left    = r_left;
        n_shift   = r_shift;
        n_ack     = r_ack;
        n_accum   = r_accum;
        n_addr    = r_addr;
        n_index   = r_index;
        n_wdata   = r_wdata;
        n_is_read = r_is_read;
        n_abort   = r_abort;
        n_done    = 1'b0;
        if (i_accept) begin
            if (i_item.mode == i2cram_pkg::MODE_CMD) begin
                if (r_phase == i2cram_pkg::PH_IDLE) begin
                    n_addr    = i_item.dev_addr;
                    n_index   = i_item.reg_index;
                    n_is_read = i_item.is_read;
                    n_wdata   = i_item.write_data << w_wshift;
                    n_left    = w_count;
                    n_accum   = '0;
                    n_ack     = '0;
                    n_abort   = 1'b0;
                    n_shift   = i_item.dev_addr;
                    n_bit     = 3'd0;
                    n_stage   = i2cram_pkg::SG_ADDR_W;
                    n_phase   = i2cram_pkg::PH_ST_A;
                    n_timer   = '0;
                end
            end else if (r_phase == i2cram_pkg::PH_AK_HI) begin
                if (!i_item.sda_in) begin
                    n_timer = '0;
                    unique case (r_stage)
                        i2cram_pkg::SG_ADDR_W: begin
                            n_shift = r_index;
                            n_bit   = 3'd0;
                            n_stage = i2cram_pkg::SG_INDEX;
                            n_phase = i2cram_pkg::PH_TX_LO;
                        end
                        i2cram_pkg::SG_INDEX: begin
                            if (r_is_read) begin
                                n_stage = i2cram_pkg::SG_ADDR_R;
                                n_phase = i2cram_pkg::PH_RS_A;
                            end else if (r_left != 3'd0) begin
                                n_shift = r_wdata[31:24];
                                n_wdata = r_wdata << 8;
                                n_bit   = 3'd0;
                                n_stage = i2cram_pkg::SG_WDATA;
                                n_phase = i2cram_pkg::PH_TX_LO;
                            end else begin
                                n_phase = i2cram_pkg::PH_SP_A;
                            end
                        end
                        i2cram_pkg::SG_WDATA: begin
                            n_left = w_left_dec;
                            if (w_left_dec != 3'd0) begin
                                n_shift = r_wdata[31:24];
                                n_wdata = r_wdata << 8;
                                n_bit   = 3'd0;
                                n_phase = i2cram_pkg::PH_TX_LO;
                            end else begin
                                n_phase = i2cram_pkg::PH_SP_A;
                            end
                        end
                        i2cram_pkg::SG_ADDR_R: begin
                            n_shift = 8'd0;
                            n_bit   = 3'd0;
                            n_phase = i2cram_pkg::PH_RX_LO;
                        end
                        default: n_phase = i2cram_pkg::PH_SP_A;
                    endcase
                end else if (r_ack >= i_ack_timeout) begin
                    n_abort = 1'b1;
                    n_timer = '0;
                    n_phase = i2cram_pkg::PH_SP_A;
                end else begin
                    n_ack = r_ack + 1'b1;
                end
            end else if (r_phase != i2cram_pkg::PH_IDLE) begin
                if (w_tick_cnt < w_len) begin
                    n_timer = w_tick_cnt;
                end else begin
                    n_timer = '0;
                    unique case (r_phase)
                        i2cram_pkg::PH_ST_A:  n_phase = i2cram_pkg::PH_ST_B;
                        i2cram_pkg::PH_ST_B:  n_phase = i2cram_pkg::PH_ST_C;
                        i2cram_pkg::PH_ST_C: begin
                            n_bit   = 3'd0;
                            n_phase = i2cram_pkg::PH_TX_LO;
                        end
                        i2cram_pkg::PH_TX_LO: n_phase = i2cram_pkg::PH_TX_HI;
                        i2cram_pkg::PH_TX_HI: begin
                            if (r_bit == 3'd7) begin
                                n_ack   = '0;
                                n_phase = i2cram_pkg::PH_AK_LO;
                            end else begin
                                n_bit   = r_bit + 3'd1;
                                n_shift = r_shift << 1;
                                n_phase = i2cram_pkg::PH_TX_LO;
                            end
                        end
                        i2cram_pkg::PH_AK_LO: n_phase = i2cram_pkg::PH_AK_HI;
                        i2cram_pkg::PH_RX_LO: n_phase = i2cram_pkg::PH_RX_HI;
                        i2cram_pkg::PH_RX_HI: begin
                            n_shift = {r_shift[6:0], i_item.sda_in};
                            if (r_bit == 3'd7) begin
                                n_accum = {r_accum[23:0], r_shift[6:0], i_item.sda_in};
                                n_phase = i2cram_pkg::PH_MA_LO;
                            end else begin
                                n_bit   = r_bit + 3'd1;
                                n_phase = i2cram_pkg::PH_RX_LO;
                            end
                        end
                        i2cram_pkg::PH_MA_LO: n_phase = i2cram_pkg::PH_MA_HI;
                        i2cram_pkg::PH_MA_HI: begin
                            n_left = w_left_dec;
                            if (w_left_dec != 3'd0) begin
                                n_shift = 8'd0;
                                n_bit   = 3'd0;
                                n_phase = i2cram_pkg::PH_RX_LO;
                            end else begin
                                n_phase = i2cram_pkg::PH_SP_A;
                            end
                        end
                        i2cram_pkg::PH_SP_A:  n_phase = i2cram_pkg::PH_SP_B;
                        i2cram_pkg::PH_SP_B:  n_phase = i2cram_pkg::PH_SP_C;
                        i2cram_pkg::PH_SP_C: begin
                            n_phase = i2cram_pkg::PH_IDLE;
                            n_done  = 1'b1;
                        end
                        i2cram_pkg::PH_RS_A: begin
                            n_shift = r_addr | 8'h01;
                            n_phase = i2cram_pkg::PH_ST_A;
                        end
                        default: n_phase = i2cram_pkg::PH_IDLE;
                    endcase
                end
            end
        end
    end

    // bus levels follow the phase just entered
    assign w_tx_bit = n_shift[7];
    assign w_ma_bit = (n_left <= 3'd1);

    always_comb begin
        o_res            = '0;
        o_res.busy_res   = (n_phase != i2cram_pkg::PH_IDLE);
        o_res.done_res   = n_done;
        o_res.nack_error = n_done && n_abort;
        o_res.read_data  = (n_done && !n_abort && n_is_read) ? n_accum : 32'd0;
        unique case (n_phase)
            i2cram_pkg::PH_ST_A:  {o_res.scl_out, o_res.sda_out, o_res.sda_drive} = 3'b111;
            i2cram_pkg::PH_ST_B:  {o_res.scl_out, o_res.sda_out, o_res.sda_drive} = 3'b101;
            i2cram_pkg::PH_ST_C:  {o_res.scl_out, o_res.sda_out, o_res.sda_drive} = 3'b001;
            i2cram_pkg::PH_TX_LO: {o_res.scl_out, o_res.sda_out, o_res.sda_drive} =
                                      {1'b0, w_tx_bit, 1'b1};
            i2cram_pkg::PH_TX_HI: {o_res.scl_out, o_res.sda_out, o_res.sda_drive} =
                                      {1'b1, w_tx_bit, 1'b1};
            i2cram_pkg::PH_AK_LO,
            i2cram_pkg::PH_RX_LO: {o_res.scl_out, o_res.sda_out, o_res.sda_drive} = 3'b010;
            i2cram_pkg::PH_AK_HI,
            i2cram_pkg::PH_RX_HI: {o_res.scl_out, o_res.sda_out, o_res.sda_drive} = 3'b110;
            i2cram_pkg::PH_MA_LO: {o_res.scl_out, o_res.sda_out, o_res.sda_drive} =
                                      {1'b0, w_ma_bit, 1'b1};
            i2cram_pkg::PH_MA_HI: {o_res.scl_out, o_res.sda_out, o_res.sda_drive} =
                                      {1'b1, w_ma_bit, 1'b1};
            i2cram_pkg::PH_SP_A:  {o_res.scl_out, o_res.sda_out, o_res.sda_drive} = 3'b001;
            i2cram_pkg::PH_SP_B:  {o_res.scl_out, o_res.sda_out, o_res.sda_drive} = 3'b101;
            i2cram_pkg::PH_SP_C:  {o_res.scl_out, o_res.sda_out, o_res.sda_drive} = 3'b111;
            i2cram_pkg::PH_RS_A:  {o_res.scl_out, o_res.sda_out, o_res.sda_drive} = 3'b011;
            default:              {o_res.scl_out, o_res.sda_out, o_res.sda_drive} = 3'b110;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2cram_pkg::PH_IDLE;
            r_stage   <= i2cram_pkg::SG_ADDR_W;
            r_timer   <= '0;
            r_bit     <= '0;
            r_left    <= '0;
            r_shift   <= '0;
            r_ack     <= '0;
            r_accum   <= '0;
            r_addr    <= '0;
            r_index   <= '0;
            r_wdata   <= '0;
            r_is_read <= 1'b0;
            r_abort   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_stage   <= n_stage;
            r_timer   <= n_timer;
            r_bit     <= n_bit;
            r_left    <= n_left;
            r_shift   <= n_shift;
            r_ack     <= n_ack;
            r_accum   <= n_accum;
            r_addr    <= n_addr;
            r_index   <= n_index;
            r_wdata   <= n_wdata;
            r_is_read <= n_is_read;
            r_abort   <= n_abort;
        end
    end

endmodule

/* rtl/i2cram_out.sv */
module i2cram_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  i2cram_pkg::t_res i_res,
    input  logic             i_m_tready,
    output logic             o_s_ready,
    output logic             o_m_tvalid,
    output i2cram_pkg::t_res o_res
);

    logic             r_valid;
    i2cram_pkg::t_res r_res;

    // room when empty or when the held item leaves this cycle
    assign o_s_ready  = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
    import i2cram_pkg::*;

    localparam int RANDOM_ITEMS = 300;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    i2c_register_access_master u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // bus master state as the block should hold it
    t_phase             m_phase;
    t_stage             m_stage;
    int unsigned        m_timer;
    int unsigned        m_ack_wait;
    logic [2:0]         m_bit;
    logic [2:0]         m_left;
    logic [7:0]         m_shift;
    logic [7:0]         m_addr;
    logic [7:0]         m_index;
    logic [31:0]        m_accum;
    logic [31:0]        m_wdata;
    logic               m_read;
    logic               m_abort;
    logic [PHASE_W-1:0] cfg_phase_len;
    logic [ACK_W-1:0]   cfg_ack_limit;

    t_res bus_outputs[$];
    int   errors = 0;
    int   sent_items = 0;
    bit   calm = 1'b0;
    int   noise_pct = 0;

    // how the emulated slave answers an acknowledge
    bit          refuse_on = 1'b0;
    t_stage      refuse_stage = SG_ADDR_W;
    int unsigned ack_hold = 0;

    function automatic void goto_phase(t_phase p);
        m_phase = p;
        m_timer = 0;
    endfunction

    function automatic void load_byte(logic [7:0] b, t_stage s);
        m_shift = b;
        m_bit = 3'd0;
        m_stage = s;
        goto_phase(PH_TX_LO);
    endfunction

    function automatic void next_wbyte();
        logic [7:0] b;
        b = m_wdata[31:24];
        m_wdata = m_wdata << 8;
        load_byte(b, SG_WDATA);
    endfunction

    function automatic t_res advance_master(t_item it);
        t_res        r;
        logic        fin;
        logic [2:0]  lines;
        int unsigned len;
        int unsigned n;
        fin = 1'b0;
        if (it.mode == MODE_CMD) begin
            if (m_phase == PH_IDLE) begin
                n = it.byte_count;
                if (n < 1) n = 1;
                if (n > BYTE_LIMIT) n = BYTE_LIMIT;
                m_addr = it.dev_addr;
                m_index = it.reg_index;
                m_read = it.is_read;
                m_wdata = it.write_data << (8 * (4 - n));
                m_left = 3'(n);
                m_accum = '0;
                m_ack_wait = 0;
                m_abort = 1'b0;
                m_shift = it.dev_addr;
                m_bit = 3'd0;
                m_stage = SG_ADDR_W;
                goto_phase(PH_ST_A);
            end
        end else if (m_phase != PH_IDLE) begin
            if (m_phase == PH_AK_HI) begin
                if (!it.sda_in) begin
                    case (m_stage)
                        SG_ADDR_W: load_byte(m_index, SG_INDEX);
                        SG_INDEX: begin
                            if (m_read) begin
                                m_stage = SG_ADDR_R;
                                goto_phase(PH_RS_A);
                            end else if (m_left > 0) begin
                                next_wbyte();
                            end else begin
                                goto_phase(PH_SP_A);
                            end
                        end
                        SG_WDATA: begin
                            if (m_left > 0) m_left--;
                            if (m_left > 0) next_wbyte();
                            else goto_phase(PH_SP_A);
                        end
                        default: begin
                            m_shift = '0;
                            m_bit = 3'd0;
                            goto_phase(PH_RX_LO);
                        end
                    endcase
                end else if (m_ack_wait >= cfg_ack_limit) begin
                    m_abort = 1'b1;
                    goto_phase(PH_SP_A);
                end else begin
                    m_ack_wait++;
                end
            end else begin
                len = (cfg_phase_len == 0) ? 1 : cfg_phase_len;
                m_timer++;
                if (m_timer >= len) begin
                    case (m_phase)
                        PH_ST_A: goto_phase(PH_ST_B);
                        PH_ST_B: goto_phase(PH_ST_C);
                        PH_ST_C: begin
                            m_bit = 3'd0;
                            goto_phase(PH_TX_LO);
                        end
                        PH_TX_LO: goto_phase(PH_TX_HI);
                        PH_TX_HI: begin
                            if (m_bit == 3'd7) begin
                                m_ack_wait = 0;
                                goto_phase(PH_AK_LO);
                            end else begin
                                m_bit++;
                                m_shift = m_shift << 1;
                                goto_phase(PH_TX_LO);
                            end
                        end
                        PH_AK_LO: goto_phase(PH_AK_HI);
                        PH_RX_LO: goto_phase(PH_RX_HI);
                        PH_RX_HI: begin
                            m_shift = {m_shift[6:0], it.sda_in};
                            if (m_bit == 3'd7) begin
                                m_accum = {m_accum[23:0], m_shift};
                                goto_phase(PH_MA_LO);
                            end else begin
                                m_bit++;
                                goto_phase(PH_RX_LO);
                            end
                        end
                        PH_MA_LO: goto_phase(PH_MA_HI);
                        PH_MA_HI: begin
                            if (m_left > 0) m_left--;
                            if (m_left > 0) begin
                                m_shift = '0;
                                m_bit = 3'd0;
                                goto_phase(PH_RX_LO);
                            end else begin
                                goto_phase(PH_SP_A);
                            end
                        end
                        PH_SP_A: goto_phase(PH_SP_B);
                        PH_SP_B: goto_phase(PH_SP_C);
                        PH_SP_C: begin
                            goto_phase(PH_IDLE);
                            fin = 1'b1;
                        end
                        PH_RS_A: begin
                            m_shift = m_addr | 8'h01;
                            goto_phase(PH_ST_A);
                        end
                        default: goto_phase(PH_IDLE);
                    endcase
                end
            end
        end

        // scl, sda level, sda drive
        case (m_phase)
            PH_ST_A:            lines = 3'b111;
            PH_ST_B:            lines = 3'b101;
            PH_ST_C:            lines = 3'b001;
            PH_TX_LO:           lines = {1'b0, m_shift[7], 1'b1};
            PH_TX_HI:           lines = {1'b1, m_shift[7], 1'b1};
            PH_AK_LO, PH_RX_LO: lines = 3'b010;
            PH_AK_HI, PH_RX_HI: lines = 3'b110;
            PH_MA_LO:           lines = {1'b0, m_left <= 3'd1, 1'b1};
            PH_MA_HI:           lines = {1'b1, m_left <= 3'd1, 1'b1};
            PH_SP_A:            lines = 3'b001;
            PH_SP_B:            lines = 3'b101;
            PH_SP_C:            lines = 3'b111;
            PH_RS_A:            lines = 3'b011;
            default:            lines = 3'b110;
        endcase
        r.scl_out = lines[2];
        r.sda_out = lines[1];
        r.sda_drive = lines[0];
        r.busy_res = (m_phase != PH_IDLE);
        r.done_res = fin;
        r.nack_error = fin && m_abort;
        r.read_data = (fin && !m_abort && m_read) ? m_accum : 32'd0;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_item any_item(t_mode md);
        t_item it;
        it.mode = md;
        it.dev_addr = 8'($urandom_range(0, 255));
        it.reg_index = 8'($urandom_range(0, 255));
        it.is_read = 1'($urandom_range(0, 1));
        it.byte_count = 3'($urandom_range(0, 7));
        it.write_data = $urandom;
        it.sda_in = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // sda follows the slave behavior while an acknowledge is awaited
    function automatic t_item tick_item();
        t_item it;
        it = any_item(MODE_TICK);
        if (m_phase == PH_AK_HI)
            it.sda_in = (refuse_on && m_stage == refuse_stage) || (m_ack_wait < ack_hold);
        return it;
    endfunction

    task automatic send_item(t_item it);
        int gap;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tuser <= it.mode;
        i_s_tdata <= {3'b000, it.sda_in, it.write_data, it.byte_count, it.is_read,
                      it.reg_index, it.dev_addr};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bus_outputs.push_back(advance_master(it));
        sent_items++;
    endtask

    task automatic finish_bus();
        while (m_phase != PH_IDLE) begin
            if ($urandom_range(0, 99) < noise_pct) send_item(any_item(MODE_CMD));
            else send_item(tick_item());
        end
    endtask

    task automatic run_txn(logic [7:0] addr, logic [7:0] idx, logic rd, logic [2:0] cnt,
                           logic [31:0] wd);
        t_item it;
        it = any_item(MODE_CMD);
        it.dev_addr = addr;
        it.reg_index = idx;
        it.is_read = rd;
        it.byte_count = cnt;
        it.write_data = wd;
        send_item(it);
        finish_bus();
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (bus_outputs.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_W-1:0] val);
        finish_bus();
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == t_cfg_phase_ticks) cfg_phase_len = val[PHASE_W-1:0];
        else cfg_ack_limit = val[ACK_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (bus_outputs.size() == 0) begin
                $error("result item with no item pending");
                errors++;
            end else begin
                want = bus_outputs.pop_front();
                check_field("scl_out", want.scl_out, o_m_tdata[0]);
                check_field("sda_out", want.sda_out, o_m_tdata[1]);
                check_field("sda_drive", want.sda_drive, o_m_tdata[2]);
                check_field("busy_res", want.busy_res, o_m_tdata[3]);
                check_field("done_res", want.done_res, o_m_tdata[4]);
                check_field("nack_error", want.nack_error, o_m_tdata[5]);
                check_field("read_data", want.read_data, o_m_tdata[37:6]);
            end
        end
    end

    // receiver stalls
    initial begin
        int n;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                i_m_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    task automatic test_idle_ticks();
        repeat (6) send_item(any_item(MODE_TICK));
    endtask

    task automatic test_default_config();
        ack_hold = 2;
        run_txn(8'hFF, 8'h00, 1'b0, 3'd1, 32'hFFFF_FFFF);
        ack_hold = 0;
    endtask

    task automatic test_byte_counts();
        int c;
        // zero phase length runs as one tick
        write_reg(t_cfg_phase_ticks, 16'd0);
        for (c = 0; c < 6; c++) begin
            ack_hold = $urandom_range(0, 2);
            run_txn(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), c[0], c[2:0],
                    $urandom);
        end
        ack_hold = 0;
    endtask

    task automatic test_ack_abort();
        int s;
        write_reg(t_cfg_phase_ticks, 16'd1);
        write_reg(t_cfg_ack_timeout, 16'd0);
        // zero timeout: one high sample at any stage aborts
        refuse_on = 1'b1;
        for (s = 0; s < 4; s++) begin
            refuse_stage = t_stage'(s);
            run_txn(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    refuse_stage == SG_ADDR_R, 3'd2, $urandom);
        end
        refuse_on = 1'b0;
        // upper bits fall outside the 12-bit register
        write_reg(t_cfg_ack_timeout, 16'hF003);
        ack_hold = 3;
        run_txn(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1, 3'd2, $urandom);
        ack_hold = 4;
        run_txn(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, 3'd2, $urandom);
        // widest timeout rides out a slow acknowledge
        write_reg(t_cfg_ack_timeout, 16'd4095);
        ack_hold = 6;
        run_txn(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, 3'd1, $urandom);
        ack_hold = 0;
    endtask

    task automatic test_busy_commands();
        write_reg(t_cfg_phase_ticks, 16'd2);
        write_reg(t_cfg_ack_timeout, 16'd2500);
        noise_pct = 25;
        run_txn(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1, 3'd2, $urandom);
        noise_pct = 0;
    endtask

    task automatic test_random();
        int first;
        int r;
        first = sent_items;
        while (sent_items - first < RANDOM_ITEMS) begin
            write_reg(t_cfg_phase_ticks, ($urandom_range(0, 9) == 0) ?
                      16'($urandom_range(4, 8)) : 16'($urandom_range(1, 3)));
            r = $urandom_range(0, 99);
            if (r < 60) write_reg(t_cfg_ack_timeout, 16'($urandom_range(2, 10)));
            else if (r < 80) write_reg(t_cfg_ack_timeout, 16'($urandom_range(0, 1)));
            else if (r < 97) write_reg(t_cfg_ack_timeout, 16'd2500);
            else write_reg(t_cfg_ack_timeout, 16'($urandom_range(11, 4095)));
            calm = ($urandom_range(0, 3) == 0);
            repeat (3) begin
                ack_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) :
                           $urandom_range(3, 8);
                refuse_on = ($urandom_range(0, 19) == 0);
                refuse_stage = t_stage'($urandom_range(0, 3));
                noise_pct = ($urandom_range(0, 3) == 0) ? 10 : 0;
                // ticks on an idle bus
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 4)) send_item(any_item(MODE_TICK));
                run_txn(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom);
            end
        end
        calm = 1'b0;
        refuse_on = 1'b0;
        noise_pct = 0;
        ack_hold = 0;
    endtask

    // longest phase: the bus holds the first start phase
    task automatic test_slow_phase();
        write_reg(t_cfg_phase_ticks, 16'hFFFF);
        calm = 1'b1;
        send_item(any_item(MODE_CMD));
        repeat (16) send_item(tick_item());
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = t_cfg_phase_ticks;
        i_cfg_data = '0;
        m_phase = PH_IDLE;
        m_stage = SG_ADDR_W;
        m_timer = 0;
        m_ack_wait = 0;
        m_bit = '0;
        m_left = '0;
        m_shift = '0;
        m_addr = '0;
        m_index = '0;
        m_accum = '0;
        m_wdata = '0;
        m_read = 1'b0;
        m_abort = 1'b0;
        cfg_phase_len = PHASE_TICKS_RST;
        cfg_ack_limit = ACK_TIMEOUT_RST;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_ticks();
        test_default_config();
        test_byte_counts();
        test_ack_abort();
        test_busy_commands();
        test_random();
        test_slow_phase();

        drain();
        repeat (5) @(posedge i_clk);
        if (errors == 0) $display("PASS i2c_register_access_master");
        else $display("FAIL i2c_register_access_master");
        $finish;
    end

    initial begin
        #(40_000_000);
        $display("FAIL i2c_register_access_master");
        $finish;
    end

endmodule
